>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent checks used in the RTL. Each expects clk_i
// and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");

// Check that a condition implies a consequence in the same cycle
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/ost_pkg.sv
// ----------------------------------------------------------------------------
// ost_pkg
// Shared widths, codes and types of the order statistic store.
// ----------------------------------------------------------------------------
package ost_pkg;

  // Default number of stored ratings
  localparam int unsigned CAPACITY = 1024;

  // Field widths
  localparam int unsigned RATING_W = 16;
  localparam int unsigned RANK_W   = 11;
  localparam int unsigned STATUS_W = 2;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  // Result of one item
  typedef struct packed {
    logic [STATUS_W-1:0]        status;
    logic signed [RATING_W-1:0] rating;
  } res_t;

endpackage

>>> hw/rtl/ost_in_if.sv
// ----------------------------------------------------------------------------
// ost_in_if
// Request channel: operation, rating and rank with valid/ready.
// ----------------------------------------------------------------------------
interface ost_in_if;
  logic                                valid;
  logic                                ready;
  logic                                op;
  logic signed [ost_pkg::RATING_W-1:0] rating;
  logic [ost_pkg::RANK_W-1:0]          rank;

  modport source (output valid, output op, output rating, output rank, input ready);
  modport sink   (input valid, input op, input rating, input rank, output ready);
endinterface

>>> hw/rtl/ost_out_if.sv
// ----------------------------------------------------------------------------
// ost_out_if
// Result channel: status and rating with valid/ready.
// ----------------------------------------------------------------------------
interface ost_out_if;
  logic                                valid;
  logic                                ready;
  logic [ost_pkg::STATUS_W-1:0]        status;
  logic signed [ost_pkg::RATING_W-1:0] rating_out;

  modport source (output valid, output status, output rating_out, input ready);
  modport sink   (input valid, input status, input rating_out, output ready);
endinterface

>>> hw/rtl/ost_ram.sv
// ----------------------------------------------------------------------------
// ost_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ost_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/ost_seq.sv
// ----------------------------------------------------------------------------
// ost_seq
// Sequencer of the store: inserts walk down from the top entry, comparing
// one entry per cycle and shifting larger ones up; queries read one entry.
// ----------------------------------------------------------------------------
module ost_seq #(
  parameter int unsigned CAPACITY = ost_pkg::CAPACITY,
  localparam int unsigned AW = $clog2(CAPACITY),
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ost_in_if.sink                        in_i,
  output logic                          res_valid_o,
  output ost_pkg::res_t                 res_o,
  input  logic                          res_ready_i,
  output logic                          ram_we_o,
  output logic [AW-1:0]                 ram_waddr_o,
  output logic [ost_pkg::RATING_W-1:0]  ram_wdata_o,
  output logic [AW-1:0]                 ram_raddr_o,
  input  logic [ost_pkg::RATING_W-1:0]  ram_rdata_i
);

  localparam int unsigned MW = (CW > ost_pkg::RANK_W) ? CW : ost_pkg::RANK_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMP  = 3'd1;
  localparam logic [2:0] S_WRV  = 3'd2;
  localparam logic [2:0] S_QRD  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]                          state_q, state_d;
  logic [CW-1:0]                       count_q, count_d;
  logic [AW-1:0]                       pos_q, pos_d;
  logic signed [ost_pkg::RATING_W-1:0] val_q, val_d;
  ost_pkg::res_t                       res_q, res_d;

  logic [MW-1:0] rank_x;
  logic [MW-1:0] count_x;
  logic [MW-1:0] diff_x;
  logic          full;
  logic          rank_bad;
  logic          shift_up;

  // Rank check and query index
  assign rank_x   = MW'(in_i.rank);
  assign count_x  = MW'(count_q);
  assign diff_x   = count_x - rank_x;
  assign full     = (count_q == CW'(CAPACITY));
  assign rank_bad = (rank_x == '0) || (rank_x > count_x);

  // Shared compare: stored entry above the new rating moves up one place
  assign shift_up = ($signed(ram_rdata_i) > val_q);

  // Next state and memory control
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    val_d       = val_q;
    res_d       = res_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = pos_q;
    ram_wdata_o = val_q;
    ram_raddr_o = pos_q - AW'(1);

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          case (in_i.op)
            ost_pkg::OP_INSERT: begin
              if (full) begin
                res_d   = '{status: ost_pkg::ST_FULL, rating: '0};
                state_d = S_DONE;
              end else if (count_q == '0) begin
                ram_we_o    = 1'b1;
                ram_waddr_o = '0;
                ram_wdata_o = in_i.rating;
                count_d     = count_q + CW'(1);
                res_d       = '{status: ost_pkg::ST_OK, rating: '0};
                state_d     = S_DONE;
              end else begin
                pos_d       = count_q[AW-1:0];
                val_d       = in_i.rating;
                ram_raddr_o = count_q[AW-1:0] - AW'(1);
                state_d     = S_CMP;
              end
            end
            default: begin
              if (rank_bad) begin
                res_d   = '{status: ost_pkg::ST_RANGE, rating: '0};
                state_d = S_DONE;
              end else begin
                ram_raddr_o = diff_x[AW-1:0];
                state_d     = S_QRD;
              end
            end
          endcase
        end
      end

      S_CMP: begin
        if (shift_up) begin
          // Move the larger entry up and look at the one below
          ram_we_o    = 1'b1;
          ram_waddr_o = pos_q;
          ram_wdata_o = ram_rdata_i;
          pos_d       = pos_q - AW'(1);
          ram_raddr_o = pos_q - AW'(2);
          if (pos_q == AW'(1)) begin
            state_d = S_WRV;
          end
        end else begin
          ram_we_o    = 1'b1;
          ram_waddr_o = pos_q;
          ram_wdata_o = val_q;
          count_d     = count_q + CW'(1);
          res_d       = '{status: ost_pkg::ST_OK, rating: '0};
          state_d     = S_DONE;
        end
      end

      S_WRV: begin
        // New rating is the smallest: place it at the bottom
        ram_we_o    = 1'b1;
        ram_waddr_o = pos_q;
        ram_wdata_o = val_q;
        count_d     = count_q + CW'(1);
        res_d       = '{status: ost_pkg::ST_OK, rating: '0};
        state_d     = S_DONE;
      end

      S_QRD: begin
        res_d   = '{status: ost_pkg::ST_OK, rating: ram_rdata_i};
        state_d = S_DONE;
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    val_q <= val_d;
    res_q <= res_d;
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

endmodule

>>> hw/rtl/order_statistic_store.sv
// ----------------------------------------------------------------------------
// order_statistic_store
// Bounded sorted multiset of signed ratings answering k-th largest queries.
// ----------------------------------------------------------------------------
//  channel | dir | fields                 | handshake
//  in_i    | in  | op, rating, rank       | valid/ready
//  out_o   | out | status, rating_out     | valid/ready
//
//  An insert into an empty store writes directly and one into a full store
//  reports ST_FULL; else the walk moves larger entries up with one compare
//  and one RAM read/write per cycle. A query reads the entry at count - rank
//  into S_QRD, or reports ST_RANGE if the rank is out of range. Reset clears
//  the control registers, not the RAM. A stalled output register holds one
//  result while the next item is taken; that item waits in its final state.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module order_statistic_store #(
  parameter int unsigned CAPACITY = ost_pkg::CAPACITY
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ost_in_if.sink     in_i,
  ost_out_if.source  out_o
);

  localparam int unsigned AW = $clog2(CAPACITY);

  logic                         res_valid;
  logic                         res_ready;
  ost_pkg::res_t                res;
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [ost_pkg::RATING_W-1:0] ram_wdata;
  logic [AW-1:0]                ram_raddr;
  logic [ost_pkg::RATING_W-1:0] ram_rdata;

  logic          out_valid_q;
  ost_pkg::res_t out_data_q;

  ost_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  ost_ram #(
    .WIDTH (ost_pkg::RATING_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_data_q.status;
  assign out_o.rating_out = out_data_q.rating;

  // Checks
  `ASSERT_NEXT(busy_after_accept, in_i.valid && in_i.ready, !in_i.ready)
  `ASSERT_NEXT(res_held_on_stall, res_valid && !res_ready, res_valid && $stable(res))
  `ASSERT_IMPL(zero_unless_found, out_valid_q && out_data_q.status != ost_pkg::ST_OK ||
               res_valid && res.status == ost_pkg::ST_FULL,
               (out_valid_q ? out_data_q.rating : res.rating) == '0 ||
               out_valid_q && out_data_q.status == ost_pkg::ST_OK)
  `ASSERT_IMPL(status_known, out_valid_q,
               out_data_q.status == ost_pkg::ST_OK || out_data_q.status == ost_pkg::ST_FULL ||
               out_data_q.status == ost_pkg::ST_RANGE)

endmodule
